// ===== src/pswi_pkg.sv =====
package pswi_pkg;

    // Ring geometry. The slot count must be a power of two.
    localparam int SLOT_COUNT = 16;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);

    // Datapath widths.
    localparam int DATA_W  = 32;
    localparam int OPND_W  = 33;
    localparam int PROD_W  = 2 * OPND_W;
    localparam int ACC_W   = 68;
    localparam int INTEG_W = 48;
    localparam int DVD_W   = 64;
    localparam int CNT_W   = $clog2(DVD_W + 1);

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_GAIN_P      = 2'd0,
        CFG_GAIN_I      = 2'd1,
        CFG_GAIN_D      = 2'd2,
        CFG_WINDOW_TIME = 2'd3
    } cfg_index_t;

    // Datapath operations issued by the controller, one per cycle.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_DSTART,
        OP_DFIN,
        OP_MUL_EFF,
        OP_ACC_EFF,
        OP_WALK_STEP,
        OP_WALK_END,
        OP_WALK_ACC,
        OP_LAST_MUL,
        OP_LAST_ACC,
        OP_MERGE_MUL,
        OP_MSTART,
        OP_MFIN,
        OP_WRITE_N,
        OP_WRITE_H,
        OP_P_MUL,
        OP_P_ACC,
        OP_D_ACC,
        OP_IH_ACC,
        OP_IL_ACC,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic need_deriv;
        logic walk_go;
        logic merge_div;
        logic div_busy;
        logic out_busy;
    } dp_status_t;

    // Ring successor of a slot index.
    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] h);
        logic [SLOT_W-1:0] n;
        if (h == SLOT_W'(SLOT_COUNT - 1))
            n = '0;
        else
            n = h + 1'b1;
        return n;
    endfunction

endpackage

// ===== src/pswi_div.sv =====
module pswi_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [pswi_pkg::DVD_W-1:0]     dividend,
    input  logic [pswi_pkg::DATA_W-1:0]    divisor,
    output logic                           busy,
    output logic [pswi_pkg::DVD_W-1:0]     quotient
);

    logic                           busy_reg;
    logic [pswi_pkg::CNT_W-1:0]     count_reg;
    logic [pswi_pkg::DVD_W-1:0]     dvd_reg;
    logic [pswi_pkg::DATA_W-1:0]    rem_reg;
    logic [pswi_pkg::DATA_W-1:0]    dsr_reg;
    logic [pswi_pkg::DATA_W:0]      trial;
    logic [pswi_pkg::DATA_W:0]      diff;
    logic                           ge;
    logic [pswi_pkg::DATA_W-1:0]    rem_next;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[pswi_pkg::DVD_W-1]};
        diff     = trial - {1'b0, dsr_reg};
        ge       = (trial >= {1'b0, dsr_reg});
        rem_next = ge ? diff[pswi_pkg::DATA_W-1:0] : trial[pswi_pkg::DATA_W-1:0];
    end

    // Control: run one bit per cycle until the counter drains.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            count_reg <= pswi_pkg::CNT_W'(pswi_pkg::DVD_W);
        end
        else if (busy_reg)
        begin
            count_reg <= count_reg - 1'b1;
            if (count_reg == pswi_pkg::CNT_W'(1))
                busy_reg <= 1'b0;
        end
    end

    // Operands; the dividend register fills with quotient bits from the bottom.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[pswi_pkg::DVD_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = dvd_reg;

endmodule

// ===== src/pswi_datapath.sv =====
module pswi_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pswi_pkg::dp_cmd_t                   cmd,
    output pswi_pkg::dp_status_t                status,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [pswi_pkg::DATA_W-1:0]         cfg_data,
    input  logic signed [pswi_pkg::DATA_W-1:0]  error_in,
    input  logic [pswi_pkg::DATA_W-1:0]         step_time,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [pswi_pkg::DATA_W-1:0]  drive,
    output logic                                saturated
);

    localparam int DW = pswi_pkg::DATA_W;
    localparam int SW = pswi_pkg::SLOT_W;
    localparam int SC = pswi_pkg::SLOT_COUNT;
    localparam int PW = pswi_pkg::PROD_W;
    localparam int AW = pswi_pkg::ACC_W;
    localparam int IW = pswi_pkg::INTEG_W;
    localparam int OW = pswi_pkg::OPND_W;

    // Configuration.
    logic signed [DW-1:0]   gain_p_reg;
    logic signed [DW-1:0]   gain_i_reg;
    logic signed [DW-1:0]   gain_d_reg;
    logic [DW-1:0]          window_time_reg;
    logic [DW-1:0]          share;
    logic [DW-1:0]          total;

    // Persistent state.
    logic [SW-1:0]          head_reg;
    logic signed [DW-1:0]   last_err_reg;
    logic                   first_reg;
    logic signed [IW-1:0]   integ_reg;
    logic [SC-1:0]          slot_valid_reg;
    logic signed [DW-1:0]   mem_err [SC];
    logic [DW-1:0]          mem_time [SC];
    logic signed [DW-1:0]   rd_err_reg;
    logic [DW-1:0]          rd_time_reg;

    // Per-item working registers.
    logic signed [DW-1:0]   e_reg;
    logic [DW-1:0]          step_reg;
    logic [DW-1:0]          rem_reg;
    logic [SW-1:0]          h_reg;
    logic [SW:0]            walked_reg;
    logic signed [AW-1:0]   acc_reg;
    logic signed [DW-1:0]   deriv_reg;
    logic                   dneg_reg;
    logic                   sat_reg;
    logic signed [PW-1:0]   prod_reg;
    logic signed [DW-1:0]   ce_reg;
    logic signed [DW-1:0]   ne_reg;
    logic [DW-1:0]          cd_reg;
    logic [DW-1:0]          tot_reg;
    logic [DW-1:0]          mag_reg;
    logic                   neg_reg;
    logic signed [DW-1:0]   res_reg;

    // Output register.
    logic                   out_valid_reg;
    logic signed [DW-1:0]   drive_reg;
    logic                   saturated_reg;

    // Shared multiplier.
    logic signed [OW-1:0]   mul_a;
    logic signed [OW-1:0]   mul_b;
    logic signed [PW-1:0]   prod_next;
    logic signed [AW-1:0]   prod_floor;
    logic signed [AW-1:0]   prod_full;

    // Divider.
    logic                   div_start;
    logic [pswi_pkg::DVD_W-1:0] div_dividend;
    logic [DW-1:0]          div_divisor;
    logic                   div_busy;
    logic [pswi_pkg::DVD_W-1:0] div_quo;

    // Misc combinational values.
    logic [SW-1:0]          h_succ;
    logic [SW-1:0]          rd_addr;
    logic                   wr_en;
    logic [SW-1:0]          wr_addr;
    logic signed [DW-1:0]   wr_err;
    logic [DW-1:0]          wr_time;
    logic signed [DW:0]     diff_d;
    logic [DW:0]            mag_d;
    logic signed [DW:0]     diff_m;
    logic [DW:0]            mag_m;
    logic [DW-1:0]          rem_min;
    logic signed [AW:0]     integ_sum;
    logic                   integ_ovf;
    logic                   drive_ovf;
    logic [DW-1:0]          q_lo;

    assign share  = window_time_reg >> SW;
    assign total  = share << SW;
    assign h_succ = pswi_pkg::next_slot(h_reg);

    // Operand selection for the multiplier; the product is always registered.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            pswi_pkg::OP_MUL_EFF:
            begin
                mul_a = OW'(e_reg);
                mul_b = {1'b0, rem_reg};
            end
            pswi_pkg::OP_WALK_STEP:
            begin
                mul_a = OW'(rd_err_reg);
                mul_b = {1'b0, rd_time_reg};
            end
            pswi_pkg::OP_LAST_MUL:
            begin
                mul_a = OW'(ce_reg);
                mul_b = {1'b0, rem_reg};
            end
            pswi_pkg::OP_MERGE_MUL:
            begin
                mul_a = {1'b0, mag_reg};
                mul_b = {1'b0, cd_reg};
            end
            pswi_pkg::OP_P_MUL:
            begin
                mul_a = OW'(gain_p_reg);
                mul_b = OW'(e_reg);
            end
            pswi_pkg::OP_P_ACC:
            begin
                mul_a = OW'(gain_d_reg);
                mul_b = OW'(deriv_reg);
            end
            pswi_pkg::OP_D_ACC:
            begin
                mul_a = OW'(gain_i_reg);
                mul_b = OW'(signed'(integ_reg[IW-1:16]));
            end
            pswi_pkg::OP_IH_ACC:
            begin
                mul_a = OW'(gain_i_reg);
                mul_b = {{(OW-16){1'b0}}, integ_reg[15:0]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next  = mul_a * mul_b;
    assign prod_floor = AW'(signed'(prod_reg[PW-1:16]));
    assign prod_full  = AW'(prod_reg);

    // Derivative numerator magnitude, merge difference, walk clamp, integral sum and overflow checks.
    always_comb
    begin
        diff_d    = (DW + 1)'(e_reg) - (DW + 1)'(last_err_reg);
        mag_d     = diff_d[DW] ? (DW + 1)'(-diff_d) : diff_d;
        diff_m    = (DW + 1)'(ce_reg) - (DW + 1)'(rd_err_reg);
        mag_m     = diff_m[DW] ? (DW + 1)'(-diff_m) : diff_m;
        rem_min   = (rem_reg > rd_time_reg) ? rd_time_reg : rem_reg;
        integ_sum = (AW + 1)'(integ_reg) + (AW + 1)'(acc_reg);
        integ_ovf = !((&integ_sum[AW:IW-1]) || !(|integ_sum[AW:IW-1]));
        drive_ovf = !((&acc_reg[AW-1:DW-1]) || !(|acc_reg[AW-1:DW-1]));
        q_lo      = div_quo[DW-1:0];
    end

    // Divider hookup: derivative or duration-weighted merge.
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = {{(pswi_pkg::DVD_W - DW - 17){1'b0}}, mag_d, 16'h0000};
        div_divisor  = step_reg;
        if (cmd.op == pswi_pkg::OP_DSTART)
            div_start = status.need_deriv;
        else if (cmd.op == pswi_pkg::OP_MSTART)
        begin
            div_start    = status.merge_div;
            div_dividend = prod_reg[pswi_pkg::DVD_W-1:0];
            div_divisor  = tot_reg;
        end
    end

    pswi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // Slot store write port and read address.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = h_reg;
        wr_err  = e_reg;
        wr_time = rd_time_reg;
        rd_addr = (cmd.op == pswi_pkg::OP_LAST_MUL) ? h_succ : h_reg;
        unique case (cmd.op)
            pswi_pkg::OP_WALK_STEP:
                wr_en = 1'b1;
            pswi_pkg::OP_WRITE_N:
            begin
                wr_en   = 1'b1;
                wr_addr = h_succ;
                wr_err  = res_reg;
                wr_time = tot_reg;
            end
            pswi_pkg::OP_WRITE_H:
            begin
                wr_en   = 1'b1;
                wr_time = rem_reg;
            end
            default:
                wr_en = 1'b0;
        endcase
    end

    // Slot store; an entry not written since the last clear reads as the reset slot.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_err[wr_addr]  <= wr_err;
            mem_time[wr_addr] <= wr_time;
        end
        rd_err_reg  <= slot_valid_reg[rd_addr] ? mem_err[rd_addr] : '0;
        rd_time_reg <= slot_valid_reg[rd_addr] ? mem_time[rd_addr] : share;
    end

    // Configuration, ring bookkeeping and persistent state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg      <= 32'sh0001_0000;
            gain_i_reg      <= '0;
            gain_d_reg      <= '0;
            window_time_reg <= 32'h0001_0000;
            slot_valid_reg  <= '0;
            head_reg        <= '0;
            integ_reg       <= '0;
            last_err_reg    <= '0;
            first_reg       <= 1'b1;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (pswi_pkg::cfg_index_t'(cfg_index))
                    pswi_pkg::CFG_GAIN_P: gain_p_reg <= cfg_data;
                    pswi_pkg::CFG_GAIN_I: gain_i_reg <= cfg_data;
                    pswi_pkg::CFG_GAIN_D: gain_d_reg <= cfg_data;
                    pswi_pkg::CFG_WINDOW_TIME:
                    begin
                        window_time_reg <= cfg_data;
                        slot_valid_reg  <= '0;
                        head_reg        <= '0;
                        integ_reg       <= '0;
                    end
                endcase
            end
            if (wr_en)
                slot_valid_reg[wr_addr] <= 1'b1;
            if (cmd.op == pswi_pkg::OP_DSTART)
            begin
                first_reg    <= 1'b0;
                last_err_reg <= e_reg;
            end
            if (cmd.op == pswi_pkg::OP_WRITE_H)
            begin
                head_reg <= h_succ;
                if (integ_ovf)
                    integ_reg <= integ_sum[AW] ? {1'b1, {(IW-1){1'b0}}}
                                               : {1'b0, {(IW-1){1'b1}}};
                else
                    integ_reg <= integ_sum[IW-1:0];
            end
        end
    end

    // Per-item working registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        unique case (cmd.op)
            pswi_pkg::OP_LOAD:
            begin
                e_reg      <= error_in;
                step_reg   <= step_time;
                rem_reg    <= (step_time < total) ? step_time : total;
                h_reg      <= head_reg;
                walked_reg <= '0;
                sat_reg    <= 1'b0;
                deriv_reg  <= '0;
            end
            pswi_pkg::OP_DSTART:
                dneg_reg <= diff_d[DW];
            pswi_pkg::OP_DFIN:
            begin
                if (dneg_reg)
                begin
                    if (div_quo > 64'h0000_0000_8000_0000)
                    begin
                        deriv_reg <= {1'b1, {(DW-1){1'b0}}};
                        sat_reg   <= 1'b1;
                    end
                    else
                        deriv_reg <= -q_lo;
                end
                else
                begin
                    if (div_quo > 64'h0000_0000_7FFF_FFFF)
                    begin
                        deriv_reg <= {1'b0, {(DW-1){1'b1}}};
                        sat_reg   <= 1'b1;
                    end
                    else
                        deriv_reg <= q_lo;
                end
            end
            pswi_pkg::OP_ACC_EFF:
                acc_reg <= prod_floor;
            pswi_pkg::OP_WALK_STEP:
            begin
                rem_reg    <= rem_reg - rd_time_reg;
                h_reg      <= h_succ;
                walked_reg <= walked_reg + 1'b1;
            end
            pswi_pkg::OP_WALK_END:
            begin
                rem_reg <= rem_min;
                ce_reg  <= rd_err_reg;
                cd_reg  <= rd_time_reg - rem_min;
            end
            pswi_pkg::OP_WALK_ACC:
                acc_reg <= acc_reg - prod_floor;
            pswi_pkg::OP_LAST_ACC:
            begin
                acc_reg <= acc_reg - prod_floor;
                ne_reg  <= rd_err_reg;
                tot_reg <= cd_reg + rd_time_reg;
                neg_reg <= diff_m[DW];
                mag_reg <= mag_m[DW-1:0];
            end
            pswi_pkg::OP_MSTART:
                res_reg <= ne_reg;
            pswi_pkg::OP_MFIN:
                res_reg <= neg_reg ? (ne_reg - q_lo) : (ne_reg + q_lo);
            pswi_pkg::OP_WRITE_H:
                if (integ_ovf)
                    sat_reg <= 1'b1;
            pswi_pkg::OP_P_ACC:
                acc_reg <= prod_floor;
            pswi_pkg::OP_D_ACC:
                acc_reg <= acc_reg + prod_floor;
            pswi_pkg::OP_IH_ACC:
                acc_reg <= acc_reg + prod_full;
            pswi_pkg::OP_IL_ACC:
                acc_reg <= acc_reg + prod_floor;
            default:
                acc_reg <= acc_reg;
        endcase
    end

    // Output register; a beat waits here until taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.op == pswi_pkg::OP_OUT)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == pswi_pkg::OP_OUT)
        begin
            saturated_reg <= sat_reg || drive_ovf;
            if (drive_ovf)
                drive_reg <= acc_reg[AW-1] ? {1'b1, {(DW-1){1'b0}}}
                                           : {1'b0, {(DW-1){1'b1}}};
            else
                drive_reg <= acc_reg[DW-1:0];
        end
    end

    // Status toward the controller.
    always_comb
    begin
        status.need_deriv = !first_reg && (step_reg != '0);
        status.walk_go    = (rem_reg > rd_time_reg) && (walked_reg < (SW + 1)'(SC));
        status.merge_div  = (tot_reg != '0) && (cd_reg != '0);
        status.div_busy   = div_busy;
        status.out_busy   = out_valid_reg && !out_ready;
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;
    assign saturated = saturated_reg;

endmodule

// ===== src/pswi_ctrl.sv =====
module pswi_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pswi_pkg::dp_status_t status,
    output pswi_pkg::dp_cmd_t    cmd
);

    typedef enum logic [19:0] {
        ST_IDLE      = 20'h00001,
        ST_DSTART    = 20'h00002,
        ST_DWAIT     = 20'h00004,
        ST_MUL_EFF   = 20'h00008,
        ST_ACC_EFF   = 20'h00010,
        ST_WALK_TEST = 20'h00020,
        ST_WALK_ACC  = 20'h00040,
        ST_LAST_MUL  = 20'h00080,
        ST_LAST_ACC  = 20'h00100,
        ST_MERGE_MUL = 20'h00200,
        ST_MSTART    = 20'h00400,
        ST_MWAIT     = 20'h00800,
        ST_WRITE_N   = 20'h01000,
        ST_WRITE_H   = 20'h02000,
        ST_P_MUL     = 20'h04000,
        ST_P_ACC     = 20'h08000,
        ST_D_ACC     = 20'h10000,
        ST_IH_ACC    = 20'h20000,
        ST_IL_ACC    = 20'h40000,
        ST_OUT       = 20'h80000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Sequence of one item: derivative, window walk, merge, weighted sum.
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = pswi_pkg::OP_NONE;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = pswi_pkg::OP_LOAD;
                    state_next = ST_DSTART;
                end
            end
            ST_DSTART:
            begin
                cmd.op     = pswi_pkg::OP_DSTART;
                state_next = status.need_deriv ? ST_DWAIT : ST_MUL_EFF;
            end
            ST_DWAIT:
                if (!status.div_busy)
                begin
                    cmd.op     = pswi_pkg::OP_DFIN;
                    state_next = ST_MUL_EFF;
                end
            ST_MUL_EFF:
            begin
                cmd.op     = pswi_pkg::OP_MUL_EFF;
                state_next = ST_ACC_EFF;
            end
            ST_ACC_EFF:
            begin
                cmd.op     = pswi_pkg::OP_ACC_EFF;
                state_next = ST_WALK_TEST;
            end
            ST_WALK_TEST:
                if (status.walk_go)
                begin
                    cmd.op     = pswi_pkg::OP_WALK_STEP;
                    state_next = ST_WALK_ACC;
                end
                else
                begin
                    cmd.op     = pswi_pkg::OP_WALK_END;
                    state_next = ST_LAST_MUL;
                end
            ST_WALK_ACC:
            begin
                cmd.op     = pswi_pkg::OP_WALK_ACC;
                state_next = ST_WALK_TEST;
            end
            ST_LAST_MUL:
            begin
                cmd.op     = pswi_pkg::OP_LAST_MUL;
                state_next = ST_LAST_ACC;
            end
            ST_LAST_ACC:
            begin
                cmd.op     = pswi_pkg::OP_LAST_ACC;
                state_next = ST_MERGE_MUL;
            end
            ST_MERGE_MUL:
            begin
                cmd.op     = pswi_pkg::OP_MERGE_MUL;
                state_next = ST_MSTART;
            end
            ST_MSTART:
            begin
                cmd.op     = pswi_pkg::OP_MSTART;
                state_next = status.merge_div ? ST_MWAIT : ST_WRITE_N;
            end
            ST_MWAIT:
                if (!status.div_busy)
                begin
                    cmd.op     = pswi_pkg::OP_MFIN;
                    state_next = ST_WRITE_N;
                end
            ST_WRITE_N:
            begin
                cmd.op     = pswi_pkg::OP_WRITE_N;
                state_next = ST_WRITE_H;
            end
            ST_WRITE_H:
            begin
                cmd.op     = pswi_pkg::OP_WRITE_H;
                state_next = ST_P_MUL;
            end
            ST_P_MUL:
            begin
                cmd.op     = pswi_pkg::OP_P_MUL;
                state_next = ST_P_ACC;
            end
            ST_P_ACC:
            begin
                cmd.op     = pswi_pkg::OP_P_ACC;
                state_next = ST_D_ACC;
            end
            ST_D_ACC:
            begin
                cmd.op     = pswi_pkg::OP_D_ACC;
                state_next = ST_IH_ACC;
            end
            ST_IH_ACC:
            begin
                cmd.op     = pswi_pkg::OP_IH_ACC;
                state_next = ST_IL_ACC;
            end
            ST_IL_ACC:
            begin
                cmd.op     = pswi_pkg::OP_IL_ACC;
                state_next = ST_OUT;
            end
            ST_OUT:
                if (!status.out_busy)
                begin
                    cmd.op     = pswi_pkg::OP_OUT;
                    state_next = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== src/pid_sliding_window_integral_top.sv =====
// Channel   Signals                                  Direction
// input     in_valid/in_ready, error_in, step_time   into block
// output    out_valid/out_ready, drive, saturated    out of block
// config    cfg_we, cfg_index, cfg_data              into block, write only
//
// One item walks up to SLOT_COUNT slots and makes up to two divisions on the
// shared bit-serial divider (derivative and slot merge).
// Reset restores the gains and window and empties the ring and the integral
// at once through per-slot valid bits; no clearing pass.
// A finished beat waits in the output register; the next item is taken while
// it waits, and the block stalls at its end only if that beat is still held.
module pid_sliding_window_integral_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [pswi_pkg::DATA_W-1:0]  error_in,
    input  logic [pswi_pkg::DATA_W-1:0]         step_time,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [pswi_pkg::DATA_W-1:0]  drive,
    output logic                                saturated,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [pswi_pkg::DATA_W-1:0]         cfg_data
);

    pswi_pkg::dp_cmd_t    cmd;
    pswi_pkg::dp_status_t status;

    pswi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    pswi_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .error_in  (error_in),
        .step_time (step_time),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .drive     (drive),
        .saturated (saturated)
    );

`ifndef SYNTHESIS
    // An accepted beat starts a sequence, so the input closes the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input still open after accepting a beat");

    // The divider only runs in the middle of an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        status.div_busy |-> !in_ready)
        else $error("divider busy while idle");

    // A new result never overwrites a beat that has not been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == pswi_pkg::OP_OUT) |-> (!out_valid || out_ready))
        else $error("result overwrote a pending output beat");
`endif

endmodule

// ===== bench/pid_sliding_window_integral_top_tb.sv =====
`timescale 1ns / 100ps

module pid_sliding_window_integral_top_tb;

    localparam int NSLOT      = pswi_pkg::SLOT_COUNT;
    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE     = 250;
    localparam int PHASES     = 6;
    localparam int PER_PHASE  = 125;
    localparam longint I48_MAX = 64'sd140737488355327;
    localparam longint I48_MIN = -I48_MAX - 1;
    localparam longint I32_MAX = 64'sd2147483647;
    localparam longint I32_MIN = -64'sd2147483648;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [31:0] a;       // error_in, or the register index
        logic [31:0] b;       // step_time, or the register value
        bit          typed;   // expectation written into the row
        logic [31:0] exp_drive;
        logic        exp_sat;
    } stim_row_t;

    typedef struct {
        logic [31:0] drive;
        logic        sat;
    } drive_beat_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] error_in;
    logic [31:0]        step_time;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] drive;
    logic               saturated;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;

    pid_sliding_window_integral_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .error_in  (error_in),
        .step_time (step_time),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .drive     (drive),
        .saturated (saturated),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Controller state as the bench sees it.
    longint             kp, ki, kd;
    logic [31:0]        win_cfg;
    logic signed [31:0] win_err [NSLOT];
    logic [31:0]        win_len [NSLOT];
    int                 win_head;
    logic signed [31:0] prev_err;
    longint             integ_acc;
    bit                 fresh_start;

    drive_beat_t drive_due[$];
    int          mismatches;
    int          idle_cycles;
    int          burst_left;
    int          ready_mode;
    int          ready_left;

    stim_row_t directed[] = '{
        // First sample after reset: unit proportional gain passes the error.
        '{ROW_ITEM, 32'h7FFF_FFFF, 32'd0, 1, 32'h7FFF_FFFF, 1'b0},
        // Full-scale swing over one tick saturates the derivative.
        '{ROW_ITEM, 32'h8000_0000, 32'd1, 1, 32'h8000_0000, 1'b1},
        '{ROW_ITEM, 32'h0000_0000, 32'hFFFF_FFFF, 1, 32'h0000_0000, 1'b0},
        '{ROW_CFG,  pswi_pkg::CFG_GAIN_I, 32'h0001_0000, 0, '0, 1'b0},
        '{ROW_CFG,  pswi_pkg::CFG_GAIN_D, 32'h0001_0000, 0, '0, 1'b0},
        '{ROW_ITEM, 32'h0002_0000, 32'h0000_4000, 0, '0, 1'b0},
        '{ROW_ITEM, 32'hFFFF_0000, 32'd0, 0, '0, 1'b0},
        '{ROW_ITEM, 32'h0003_0000, 32'h0002_0000, 0, '0, 1'b0},
        // Window shorter than the slot count: every slot has zero length.
        '{ROW_CFG,  pswi_pkg::CFG_WINDOW_TIME, 32'd15, 0, '0, 1'b0},
        '{ROW_ITEM, 32'h0001_0000, 32'd0, 0, '0, 1'b0},
        '{ROW_ITEM, 32'h0005_0000, 32'd7, 0, '0, 1'b0},
        '{ROW_ITEM, 32'hFFF0_0000, 32'd0, 0, '0, 1'b0},
        '{ROW_CFG,  pswi_pkg::CFG_WINDOW_TIME, 32'hFFFF_FFFF, 0, '0, 1'b0},
        // Long full-scale steps drive the integral to its limit.
        '{ROW_ITEM, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, '0, 1'b0},
        '{ROW_ITEM, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, '0, 1'b0},
        '{ROW_ITEM, 32'h7FFF_FFFF, 32'h8000_0000, 0, '0, 1'b0},
        '{ROW_CFG,  pswi_pkg::CFG_GAIN_P, 32'h7FFF_FFFF, 0, '0, 1'b0},
        '{ROW_CFG,  pswi_pkg::CFG_GAIN_I, 32'h8000_0000, 0, '0, 1'b0},
        '{ROW_ITEM, 32'h8000_0000, 32'h0000_0100, 0, '0, 1'b0},
        '{ROW_CFG,  pswi_pkg::CFG_WINDOW_TIME, 32'd1, 0, '0, 1'b0},
        '{ROW_ITEM, 32'h1234_5678, 32'd1, 0, '0, 1'b0},
        '{ROW_ITEM, 32'hEDCB_A988, 32'd2, 0, '0, 1'b0}
    };

    // Clock and the single reset at the start.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic longint clip(input longint v, input longint lo, input longint hi,
                                    inout bit flag);
        if (v > hi)
        begin
            flag = 1;
            return hi;
        end
        if (v < lo)
        begin
            flag = 1;
            return lo;
        end
        return v;
    endfunction

    function automatic void clear_window();
        for (int i = 0; i < NSLOT; i++)
        begin
            win_err[i] = '0;
            win_len[i] = win_cfg / NSLOT;
        end
        win_head  = 0;
        integ_acc = 0;
    endfunction

    function automatic void set_register(input pswi_pkg::cfg_index_t idx,
                                         input logic [31:0] val);
        case (idx)
            pswi_pkg::CFG_GAIN_P: kp = longint'(signed'(val));
            pswi_pkg::CFG_GAIN_I: ki = longint'(signed'(val));
            pswi_pkg::CFG_GAIN_D: kd = longint'(signed'(val));
            pswi_pkg::CFG_WINDOW_TIME:
            begin
                win_cfg = val;
                clear_window();
            end
        endcase
    endfunction

    // Fold the leftover of slot h into the following slot, weighted by time.
    function automatic void fold_slot(input int h);
        int                nx;
        longint unsigned   cd, nd, tot, mag, q;
        longint            ce, ne, res, diff;
        nx  = (h + 1) % NSLOT;
        cd  = win_len[h];
        nd  = win_len[nx];
        tot = cd + nd;
        ce  = win_err[h];
        ne  = win_err[nx];
        res = ne;
        if (tot != 0 && cd != 0)
        begin
            diff = ce - ne;
            mag  = diff < 0 ? longint'(-diff) : longint'(diff);
            q    = (mag * cd) / tot;
            res  = diff < 0 ? ne - longint'(q) : ne + longint'(q);
        end
        win_err[nx] = res[31:0];
        win_len[nx] = tot[31:0];
    endfunction

    // Advance the controller by one sample and return the drive it yields.
    function automatic drive_beat_t predict_drive(input logic signed [31:0] e32,
                                                  input logic [31:0] st);
        drive_beat_t       r;
        bit                sat;
        longint            e, dv, delta, p, d, ihi, ilo, it, sum, num;
        longint unsigned   total, eff, rem;
        int                h, walked;
        sat   = 0;
        e     = e32;
        dv    = 0;
        total = 0;
        for (int i = 0; i < NSLOT; i++)
            total += win_len[i];
        eff = st < total ? st : total;

        // Derivative over the unclamped step.
        if (!fresh_start && st != 0)
        begin
            num = (e - longint'(prev_err)) * 65536;
            dv  = clip(num / longint'({32'b0, st}), I32_MIN, I32_MAX, sat);
        end
        fresh_start = 0;
        prev_err    = e32;

        // Overwrite the oldest covered time with the new sample.
        h      = win_head;
        delta  = (e * longint'(eff)) >>> 16;
        rem    = eff;
        walked = 0;
        while (rem > win_len[h] && walked < NSLOT)
        begin
            delta -= (longint'(win_err[h]) * longint'({32'b0, win_len[h]})) >>> 16;
            win_err[h] = e32;
            rem -= win_len[h];
            h = (h + 1) % NSLOT;
            walked++;
        end
        if (rem > win_len[h])
            rem = win_len[h];
        delta -= (longint'(win_err[h]) * longint'(rem)) >>> 16;
        win_len[h] = win_len[h] - rem[31:0];
        fold_slot(h);
        win_len[h] = rem[31:0];
        win_err[h] = e32;
        win_head   = (h + 1) % NSLOT;

        integ_acc = clip(integ_acc + delta, I48_MIN, I48_MAX, sat);

        p   = (kp * e) >>> 16;
        d   = (kd * dv) >>> 16;
        ihi = integ_acc >>> 16;
        ilo = integ_acc - ihi * 65536;
        it  = ki * ihi + ((ki * ilo) >>> 16);
        sum = clip(p + it + d, I32_MIN, I32_MAX, sat);
        r.drive = sum[31:0];
        r.sat   = sat;
        return r;
    endfunction

    // Hand one sample to the block, with random gaps between bursts.
    task automatic send_sample(input logic [31:0] e, input logic [31:0] st,
                               input bit typed, input drive_beat_t typed_beat);
        drive_beat_t b;
        int          gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_valid  <= 1'b1;
        error_in  <= e;
        step_time <= st;
        do @(posedge clk); while (!in_ready);
        b = predict_drive(e, st);
        drive_due.push_back(typed ? typed_beat : b);
    endtask

    // Let every outstanding beat come back and, when settle is set, the block go quiet.
    task automatic wait_drained(input bit settle);
        in_valid <= 1'b0;
        while (drive_due.size() != 0) @(posedge clk);
        if (settle)
            repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_register(input pswi_pkg::cfg_index_t idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        set_register(idx, val);
    endtask

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            default: return 32'($urandom_range(0, 32'h40000)) - 32'h20000;
        endcase
    endfunction

    function automatic logic [31:0] pick_window();
        case ($urandom_range(0, 5))
            0: return 32'd1;
            1: return 32'hFFFF_FFFF;
            2: return 32'd15;
            3: return 32'h0001_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_error();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3, 4: return 32'($urandom_range(0, 32'h80000)) - 32'h40000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_step();
        case ($urandom_range(0, 9))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom();
            default: return $urandom_range(0, (win_cfg >> 3) + 1);
        endcase
    endfunction

    // Receiver stalls follow modes of random length.
    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = $urandom_range(0, 2);
            ready_left = $urandom_range(20, 300);
        end
        ready_left--;
        case (ready_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Check each drive beat against the oldest expectation.
    always @(posedge clk)
    begin
        drive_beat_t want;
        if (out_valid && out_ready)
        begin
            if (drive_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: drive=%h sat=%b", drive, saturated);
            end
            else
            begin
                want = drive_due.pop_front();
                if (drive !== want.drive || saturated !== want.sat)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: drive exp %h got %h, sat exp %b got %b",
                                 want.drive, drive, want.sat, saturated);
                end
            end
        end
    end

    // Watchdog on cycles with no beat on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("** pid_sliding_window_integral_top: FAILED **");
            $finish;
        end
    end

    initial
    begin
        drive_beat_t tb;
        mismatches  = 0;
        idle_cycles = 0;
        burst_left  = 0;
        ready_left  = 0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        error_in    = '0;
        step_time   = '0;
        out_ready   = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = pswi_pkg::CFG_GAIN_P;
        cfg_data    = '0;
        kp          = 65536;
        ki          = 0;
        kd          = 0;
        win_cfg     = 32'h0001_0000;
        prev_err    = '0;
        fresh_start = 1;
        clear_window();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows.
        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_CFG)
            begin
                wait_drained(1);
                write_register(pswi_pkg::cfg_index_t'(directed[i].a[1:0]), directed[i].b);
            end
            else
            begin
                tb.drive = directed[i].exp_drive;
                tb.sat   = directed[i].exp_sat;
                send_sample(directed[i].a, directed[i].b, directed[i].typed, tb);
            end
        end

        // Random phases, each with fresh gains and, at times, a new window.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_drained(1);
            write_register(pswi_pkg::CFG_GAIN_P, pick_gain());
            write_register(pswi_pkg::CFG_GAIN_I, pick_gain());
            write_register(pswi_pkg::CFG_GAIN_D, pick_gain());
            if (ph == 0 || $urandom_range(0, 1) == 0)
                write_register(pswi_pkg::CFG_WINDOW_TIME, pick_window());
            for (int n = 0; n < PER_PHASE; n++)
            begin
                if (ph == 1 && n == PER_PHASE / 2)
                    wait_drained(0);
                send_sample(pick_error(), pick_step(), 0, tb);
            end
        end

        wait_drained(1);
        if (mismatches == 0)
            $display("** pid_sliding_window_integral_top: PASSED **");
        else
            $display("** pid_sliding_window_integral_top: FAILED **");
        $finish;
    end

endmodule

// ===== pid_sliding_window_integral_top.f =====
src/pswi_pkg.sv
src/pswi_div.sv
src/pswi_datapath.sv
src/pswi_ctrl.sv
src/pid_sliding_window_integral_top.sv
bench/pid_sliding_window_integral_top_tb.sv
